@@ design/bdeq_pkg.sv @@
// Shared constants, command codes and store request type for the bounded deque.
`timescale 1ns / 1ps

package bdeq_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_BITS  = 64;
   localparam int INDEX_BITS = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS   = INDEX_BITS + 1;

   localparam int KIND_BITS  = 3;
   localparam int FIELD_BITS = 64;
   localparam int OUT_COUNT_BITS = 5;
   localparam int RSP_BITS   = 2 * FIELD_BITS + OUT_COUNT_BITS + 3;

   localparam logic [KIND_BITS-1:0] KIND_NONE       = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd4;

   typedef struct packed {
      logic                  wr_en;
      logic [INDEX_BITS-1:0] wr_addr;
      logic [WORD_BITS-1:0]  wr_word;
      logic                  rd_en;
      logic [INDEX_BITS-1:0] rd_front_addr;
      logic [INDEX_BITS-1:0] rd_back_addr;
   } store_req_type;

endpackage

@@ design/bdeq_store.sv @@
// Slot memory of the deque: one write port, two registered read ports.
`timescale 1ns / 1ps

module bdeq_store (
   input  logic                             clock,
   input  bdeq_pkg::store_req_type          store_req,
   output logic [bdeq_pkg::WORD_BITS-1:0]   front_word_ff,
   output logic [bdeq_pkg::WORD_BITS-1:0]   back_word_ff
);

   logic [bdeq_pkg::WORD_BITS-1:0] slot_mem [bdeq_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         slot_mem[store_req.wr_addr] <= store_req.wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         front_word_ff <= slot_mem[store_req.rd_front_addr];
         back_word_ff  <= slot_mem[store_req.rd_back_addr];
      end
   end

endmodule

@@ design/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue of 64-bit words.
//
// Usage:
//   The req channel carries one command per beat: tuser holds the kind
//   (none, push front, push back, pop front, pop back) and tdata the word to
//   push. The rsp channel returns one beat per command with the front and
//   back words after the command, the word count, empty and full flags, and
//   a refused flag for a push on a full deque or a pop on an empty one.
//   The slot memory is written in the accept cycle, read through its
//   registered ports in the next cycle (ST_READ), and the read words are
//   loaded into the response register in ST_DATA once that register is
//   free. One command is in flight at a time, so a new command is taken
//   only after the last response has been loaded.
//   A response waiting in the output register does not block the next
//   command; if the receiver stalls, the following response holds in the
//   memory read registers until the output register frees.
//   Reset empties the deque (front index and count to zero) and clears all
//   valid state; slot contents are not cleared, and unwritten words never reach a response.
`timescale 1ns / 1ps

module bounded_double_ended_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bdeq_pkg::FIELD_BITS-1:0]        req_tdata,  // value
   input  logic [bdeq_pkg::KIND_BITS-1:0]         req_tuser,  // kind
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // front_word, back_word, entry_count, is_empty, is_full, refused
   output logic [bdeq_pkg::RSP_BITS-1:0]          rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DATA
   } state_type;

   state_type                           state_ff;
   state_type                           state_in;
   logic [bdeq_pkg::INDEX_BITS-1:0]     front_index_ff;
   logic [bdeq_pkg::INDEX_BITS-1:0]     front_index_in;
   logic [bdeq_pkg::COUNT_BITS-1:0]     held_count_ff;
   logic [bdeq_pkg::COUNT_BITS-1:0]     held_count_in;
   logic                                refused_ff;
   logic                                refused_in;
   logic                                rsp_tvalid_ff;
   logic                                rsp_tvalid_in;
   logic [bdeq_pkg::RSP_BITS-1:0]       rsp_tdata_ff;
   logic [bdeq_pkg::RSP_BITS-1:0]       rsp_tdata_in;

   logic                                accept;
   logic                                is_push;
   logic                                is_pop;
   logic                                full;
   logic                                empty;
   logic                                push_ok;
   logic                                pop_ok;
   logic                                load_rsp;
   logic [bdeq_pkg::INDEX_BITS-1:0]     front_dec;
   logic [bdeq_pkg::INDEX_BITS-1:0]     front_inc;
   logic [bdeq_pkg::SUM_BITS-1:0]       tail_sum;
   logic [bdeq_pkg::SUM_BITS-1:0]       back_sum;
   logic [bdeq_pkg::INDEX_BITS-1:0]     tail_index;
   logic [bdeq_pkg::INDEX_BITS-1:0]     back_index;
   logic [bdeq_pkg::FIELD_BITS-1:0]     front_word;
   logic [bdeq_pkg::FIELD_BITS-1:0]     back_word;
   logic [bdeq_pkg::WORD_BITS-1:0]      rd_front_word;
   logic [bdeq_pkg::WORD_BITS-1:0]      rd_back_word;
   bdeq_pkg::store_req_type             store_req;

   assign accept  = (state_ff == ST_IDLE) && req_tvalid;
   assign is_push = (req_tuser == bdeq_pkg::KIND_PUSH_FRONT) ||
                    (req_tuser == bdeq_pkg::KIND_PUSH_BACK);
   assign is_pop  = (req_tuser == bdeq_pkg::KIND_POP_FRONT) ||
                    (req_tuser == bdeq_pkg::KIND_POP_BACK);
   assign full    = (held_count_ff == bdeq_pkg::COUNT_BITS'(bdeq_pkg::DEPTH));
   assign empty   = (held_count_ff == '0);
   assign push_ok = is_push && !full;
   assign pop_ok  = is_pop && !empty;

   assign front_dec = (front_index_ff == '0) ?
                      bdeq_pkg::INDEX_BITS'(bdeq_pkg::DEPTH - 1) : front_index_ff - 1'b1;
   assign front_inc = (front_index_ff == bdeq_pkg::INDEX_BITS'(bdeq_pkg::DEPTH - 1)) ?
                      '0 : front_index_ff + 1'b1;

   assign tail_sum   = bdeq_pkg::SUM_BITS'(front_index_ff) + bdeq_pkg::SUM_BITS'(held_count_ff);
   assign back_sum   = tail_sum - 1'b1;
   assign tail_index = (tail_sum >= bdeq_pkg::SUM_BITS'(bdeq_pkg::DEPTH)) ?
                       bdeq_pkg::INDEX_BITS'(tail_sum - bdeq_pkg::SUM_BITS'(bdeq_pkg::DEPTH)) :
                       bdeq_pkg::INDEX_BITS'(tail_sum);
   assign back_index = (back_sum >= bdeq_pkg::SUM_BITS'(bdeq_pkg::DEPTH)) ?
                       bdeq_pkg::INDEX_BITS'(back_sum - bdeq_pkg::SUM_BITS'(bdeq_pkg::DEPTH)) :
                       bdeq_pkg::INDEX_BITS'(back_sum);

   // Write in the accept cycle; read the updated ends in the next cycle.
   always_comb begin
      store_req.wr_en         = accept && push_ok;
      store_req.wr_addr       = (req_tuser == bdeq_pkg::KIND_PUSH_FRONT) ? front_dec : tail_index;
      store_req.wr_word       = req_tdata[bdeq_pkg::WORD_BITS-1:0];
      store_req.rd_en         = (state_ff == ST_READ);
      store_req.rd_front_addr = front_index_ff;
      store_req.rd_back_addr  = back_index;
   end

   bdeq_store u_store (
      .clock         (clock),
      .store_req     (store_req),
      .front_word_ff (rd_front_word),
      .back_word_ff  (rd_back_word)
   );

   assign front_word = empty ? '0 : bdeq_pkg::FIELD_BITS'(rd_front_word);
   assign back_word  = empty ? '0 : bdeq_pkg::FIELD_BITS'(rd_back_word);
   assign load_rsp   = (state_ff == ST_DATA) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      front_index_in = front_index_ff;
      held_count_in  = held_count_ff;
      refused_in     = refused_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in   = {refused_ff, full, empty,
                        bdeq_pkg::OUT_COUNT_BITS'(held_count_ff), back_word, front_word};
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in   = ST_READ;
               refused_in = (is_push && full) || (is_pop && empty);
               if (push_ok) begin
                  held_count_in = held_count_ff + 1'b1;
                  if (req_tuser == bdeq_pkg::KIND_PUSH_FRONT) begin
                     front_index_in = front_dec;
                  end
               end else if (pop_ok) begin
                  held_count_in = held_count_ff - 1'b1;
                  if (req_tuser == bdeq_pkg::KIND_POP_FRONT) begin
                     front_index_in = front_inc;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (load_rsp) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         front_index_ff <= '0;
         held_count_ff  <= '0;
         refused_ff     <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         front_index_ff <= front_index_in;
         held_count_ff  <= held_count_in;
         refused_ff     <= refused_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         if (load_rsp) begin
            rsp_tdata_ff <= rsp_tdata_in;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= bdeq_pkg::COUNT_BITS'(bdeq_pkg::DEPTH))
      else $error("held count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> !full)
      else $error("slot write while deque is full");

   assert property (@(posedge clock) disable iff (reset)
      (accept && push_ok) |=> (held_count_ff == $past(held_count_ff) + 1'b1))
      else $error("accepted push did not grow the count");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (is_push || is_pop) && !push_ok && !pop_ok) |=>
         (refused_ff && $stable(held_count_ff) && $stable(front_index_ff)))
      else $error("refused command changed the deque");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2*bdeq_pkg::FIELD_BITS+bdeq_pkg::OUT_COUNT_BITS]) |->
         (rsp_tdata[2*bdeq_pkg::FIELD_BITS-1:0] == '0))
      else $error("empty response carries nonzero words");
`endif

endmodule
